/* hdl/lobm_pkg.sv */
package lobm_pkg;

    localparam int TDATA_IN_W  = 184;
    localparam int TDATA_OUT_W = 256;
    localparam int CNT_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_ZERO_QTY  = 3'd1;
    localparam logic [2:0] STS_ZERO_PX   = 3'd2;
    localparam logic [2:0] STS_DUP_ID    = 3'd3;
    localparam logic [2:0] STS_UNKNOWN   = 3'd4;
    localparam logic [2:0] STS_BOOK_FULL = 3'd5;

    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_CANCEL = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;

    // Classified request as it waits between front and back
    typedef struct packed {
        logic        kind;
        logic [31:0] oid;
        logic        side;
        logic        market;
        logic [31:0] price;
        logic [31:0] open_qty;
        logic [47:0] ts;
        logic [2:0]  rej;
    } t_req;

    // One result item
    typedef struct packed {
        logic        is_trade;
        logic [2:0]  status;
        logic [31:0] maker_id;
        logic [31:0] taker_id;
        logic [31:0] trade_price;
        logic [31:0] trade_qty;
        logic [47:0] trade_ts;
        logic        aggr_side;
        logic        last;
        logic [31:0] top_bid;
        logic [31:0] top_ask;
        logic [CNT_W-1:0] count;
    } t_res;

endpackage

/* hdl/lobm_front.sv */
module lobm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lobm_pkg::TDATA_IN_W-1:0] i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_pop,
    output logic                            o_req_valid,
    output lobm_pkg::t_req                  o_req
);
    import lobm_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_req          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    t_req          w_cls;
    logic          w_push, w_pop;

    // Classify: early rejects and effective open quantity
    always_comb begin
        w_cls.kind     = i_s_tuser;
        w_cls.oid      = i_s_tdata[31:0];
        w_cls.side     = i_s_tdata[32];
        w_cls.market   = i_s_tdata[33];
        w_cls.price    = i_s_tdata[65:34];
        w_cls.open_qty = (i_s_tdata[129:98] == 32'd0) ? i_s_tdata[97:66] : i_s_tdata[129:98];
        w_cls.ts       = i_s_tdata[177:130];
        if (i_s_tdata[97:66] == 32'd0) begin
            w_cls.rej = STS_ZERO_QTY;
        end else if (!i_s_tdata[33] && i_s_tdata[65:34] == 32'd0) begin
            w_cls.rej = STS_ZERO_PX;
        end else begin
            w_cls.rej = STS_OK;
        end
    end

    assign o_s_tready  = (r_cnt != (PW+1)'(QUEUE_DEPTH));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_mem[r_rp];
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = i_pop && o_req_valid;

    // Hold requests in a short queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

endmodule

/* hdl/lobm_back.sv */
module lobm_back #(
    parameter int MAX_ORDERS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  lobm_pkg::t_req i_req,
    output logic           o_pop,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output lobm_pkg::t_res o_res
);
    import lobm_pkg::*;

    localparam int IDX_W = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CW    = $clog2(MAX_ORDERS + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state r_state;

    // Order table
    logic        r_ev   [MAX_ORDERS];
    logic        r_es   [MAX_ORDERS];
    logic [31:0] r_eid  [MAX_ORDERS];
    logic [31:0] r_epx  [MAX_ORDERS];
    logic [31:0] r_erem [MAX_ORDERS];
    logic [31:0] r_earr [MAX_ORDERS];
    logic [31:0] r_arr_ctr;

    t_req        r_req;
    logic [31:0] r_open;
    logic [2:0]  r_status;
    logic        r_first, r_final;
    t_res        r_pend, r_out;
    logic        r_ovalid;

    // Scan accumulators
    logic [IDX_W-1:0] r_idx;
    logic [CW-1:0]    r_cnt;
    logic             r_bid_hit, r_ask_hit, r_id_hit, r_free_hit;
    logic [IDX_W-1:0] r_bid_slot, r_ask_slot, r_id_slot, r_free_slot;
    logic [31:0]      r_bid_px, r_ask_px, r_bid_age, r_ask_age;
    logic [31:0]      r_bid_rem, r_ask_rem, r_bid_id, r_ask_id;

    logic        w_v, w_s;
    logic [31:0] w_px, w_age;
    logic        w_bid_take, w_ask_take;
    logic        w_out_free;
    logic        w_opp_hit, w_cross;
    logic [IDX_W-1:0] w_opp_slot;
    logic [31:0] w_opp_px, w_opp_rem, w_opp_id, w_q;
    t_res        w_close, w_close_unk, w_close_dup, w_trade;

    // Compare the scanned slot against the best so far
    always_comb begin
        w_v   = r_ev[r_idx];
        w_s   = r_es[r_idx];
        w_px  = r_epx[r_idx];
        w_age = r_arr_ctr - r_earr[r_idx];
        w_bid_take = w_v && (w_s == SIDE_BUY) && (!r_bid_hit || w_px > r_bid_px ||
                     (w_px == r_bid_px && w_age > r_bid_age));
        w_ask_take = w_v && (w_s == SIDE_SELL) && (!r_ask_hit || w_px < r_ask_px ||
                     (w_px == r_ask_px && w_age > r_ask_age));
    end

    // Match decision against the opposite best
    always_comb begin
        w_opp_hit  = (r_req.side == SIDE_BUY) ? r_ask_hit  : r_bid_hit;
        w_opp_slot = (r_req.side == SIDE_BUY) ? r_ask_slot : r_bid_slot;
        w_opp_px   = (r_req.side == SIDE_BUY) ? r_ask_px   : r_bid_px;
        w_opp_rem  = (r_req.side == SIDE_BUY) ? r_ask_rem  : r_bid_rem;
        w_opp_id   = (r_req.side == SIDE_BUY) ? r_ask_id   : r_bid_id;
        w_cross    = w_opp_hit && (r_req.market ||
                     ((r_req.side == SIDE_BUY) ? (r_req.price >= w_opp_px)
                                               : (r_req.price <= w_opp_px)));
        w_q        = (r_open < w_opp_rem) ? r_open : w_opp_rem;

        w_close         = '0;
        w_close.last    = 1'b1;
        w_close.status  = r_status;
        w_close.top_bid = r_bid_hit ? r_bid_px : 32'd0;
        w_close.top_ask = r_ask_hit ? r_ask_px : 32'd0;
        w_close.count   = CNT_W'(r_cnt);

        w_close_unk        = w_close;
        w_close_unk.status = STS_UNKNOWN;
        w_close_dup        = w_close;
        w_close_dup.status = STS_DUP_ID;

        w_trade             = '0;
        w_trade.is_trade    = 1'b1;
        w_trade.maker_id    = w_opp_id;
        w_trade.taker_id    = r_req.oid;
        w_trade.trade_price = w_opp_px;
        w_trade.trade_qty   = w_q;
        w_trade.trade_ts    = r_req.ts;
        w_trade.aggr_side   = r_req.side;
    end

    assign w_out_free  = !r_ovalid || i_res_ready;
    assign o_pop       = (r_state == S_IDLE) && i_req_valid;
    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_arr_ctr <= '0;
            for (int i = 0; i < MAX_ORDERS; i++) begin
                r_ev[i] <= 1'b0;
            end
        end else begin
            if (r_ovalid && i_res_ready && r_state != S_EMIT) r_ovalid <= 1'b0;
            unique case (r_state)
                // Take the next request and start a scan
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req      <= i_req;
                        r_open     <= i_req.open_qty;
                        r_status   <= i_req.rej;
                        r_first    <= 1'b1;
                        r_final    <= 1'b0;
                        r_idx      <= '0;
                        r_cnt      <= '0;
                        r_bid_hit  <= 1'b0;
                        r_ask_hit  <= 1'b0;
                        r_id_hit   <= 1'b0;
                        r_free_hit <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                // Walk the table one slot a cycle
                S_SCAN: begin
                    if (w_bid_take) begin
                        r_bid_hit <= 1'b1; r_bid_slot <= r_idx; r_bid_px <= w_px;
                        r_bid_age <= w_age; r_bid_rem <= r_erem[r_idx];
                        r_bid_id  <= r_eid[r_idx];
                    end
                    if (w_ask_take) begin
                        r_ask_hit <= 1'b1; r_ask_slot <= r_idx; r_ask_px <= w_px;
                        r_ask_age <= w_age; r_ask_rem <= r_erem[r_idx];
                        r_ask_id  <= r_eid[r_idx];
                    end
                    if (w_v && !r_id_hit && r_eid[r_idx] == r_req.oid) begin
                        r_id_hit <= 1'b1; r_id_slot <= r_idx;
                    end
                    if (!w_v && !r_free_hit) begin
                        r_free_hit <= 1'b1; r_free_slot <= r_idx;
                    end
                    r_cnt <= r_cnt + CW'(w_v);
                    if (r_idx == IDX_W'(MAX_ORDERS - 1)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // Act on the scan
                S_DECIDE: begin
                    r_idx      <= '0;
                    r_cnt      <= '0;
                    priority if (r_final) begin
                        r_pend  <= w_close;
                        r_state <= S_EMIT;
                    end else if (r_first && r_req.kind == KIND_CANCEL) begin
                        if (!r_id_hit) begin
                            r_pend  <= w_close_unk;
                            r_state <= S_EMIT;
                        end else begin
                            r_ev[r_id_slot] <= 1'b0;
                            r_status   <= STS_OK;
                            r_final    <= 1'b1;
                            r_bid_hit  <= 1'b0;
                            r_ask_hit  <= 1'b0;
                            r_id_hit   <= 1'b0;
                            r_free_hit <= 1'b0;
                            r_state    <= S_SCAN;
                        end
                    end else if (r_first && r_req.rej != STS_OK) begin
                        r_pend  <= w_close;
                        r_state <= S_EMIT;
                    end else if (r_first && r_id_hit) begin
                        r_pend  <= w_close_dup;
                        r_state <= S_EMIT;
                    end else if (w_cross) begin
                        r_pend  <= w_trade;
                        r_erem[w_opp_slot] <= w_opp_rem - w_q;
                        if (w_q == w_opp_rem) r_ev[w_opp_slot] <= 1'b0;
                        r_open  <= r_open - w_q;
                        r_final <= (r_open == w_q);
                        r_first <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_first <= 1'b0;
                        r_final <= 1'b1;
                        if (!r_req.market && r_free_hit) begin
                            r_ev[r_free_slot]   <= 1'b1;
                            r_es[r_free_slot]   <= r_req.side;
                            r_eid[r_free_slot]  <= r_req.oid;
                            r_epx[r_free_slot]  <= r_req.price;
                            r_erem[r_free_slot] <= r_open;
                            r_earr[r_free_slot] <= r_arr_ctr;
                            r_arr_ctr           <= r_arr_ctr + 32'd1;
                            r_status            <= STS_OK;
                        end else if (!r_req.market) begin
                            r_status <= STS_BOOK_FULL;
                        end else begin
                            r_status <= STS_OK;
                        end
                        r_bid_hit  <= 1'b0;
                        r_ask_hit  <= 1'b0;
                        r_id_hit   <= 1'b0;
                        r_free_hit <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                // Hand the result to the output register
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ovalid   <= 1'b1;
                        r_out      <= r_pend;
                        r_idx      <= '0;
                        r_cnt      <= '0;
                        r_bid_hit  <= 1'b0;
                        r_ask_hit  <= 1'b0;
                        r_id_hit   <= 1'b0;
                        r_free_hit <= 1'b0;
                        r_state    <= r_pend.last ? S_IDLE : S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_trade_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.is_trade |-> !o_res.last && o_res.status == STS_OK)
        else $error("trade result carries status or last");
    a_ctr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_arr_ctr) |-> $past(r_state == S_DECIDE))
        else $error("arrival counter moved outside decision");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_SCAN)
        else $error("request taken without a scan");

endmodule

/* hdl/limit_order_book_matcher_top.sv */
// Price-time priority order book over MAX_ORDERS resting slots. Each request is a
// submit or cancel; a submit yields one result per trade and every request ends
// with one closing status result (tlast high) carrying top bid, top ask and the
// resting count. Requests enter a two-deep queue, so the input side keeps
// accepting while the matching engine works, until the queue is full. Every
// table scan walks one slot a cycle; a hold-off on the result side stalls the
// engine in its emit state before the next scan.
module limit_order_book_matcher_top #(
    parameter int MAX_ORDERS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // id, side, order type, price, total quantity, open quantity, timestamp
    input  logic [lobm_pkg::TDATA_IN_W-1:0]  i_s_tdata,
    // kind
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // status, maker id, taker id, trade price, trade quantity, trade timestamp,
    // aggressor side, top bid price, top ask price, resting count
    output logic [lobm_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    // is_trade
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);
    import lobm_pkg::*;

    logic w_req_valid, w_pop;
    t_req w_req;
    t_res w_res;

    lobm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_pop       (w_pop),
        .o_req_valid (w_req_valid),
        .o_req       (w_req)
    );

    lobm_back #(.MAX_ORDERS(MAX_ORDERS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_pop       (w_pop),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (w_res)
    );

    // Pack the result fields
    assign o_m_tdata = {6'd0, w_res.count, w_res.top_ask, w_res.top_bid, w_res.aggr_side,
                        w_res.trade_ts, w_res.trade_qty, w_res.trade_price,
                        w_res.taker_id, w_res.maker_id, w_res.status};
    assign o_m_tuser = w_res.is_trade;
    assign o_m_tlast = w_res.last;

endmodule
